[src/fpc_pkg.sv]
package fpc_pkg;

  typedef enum logic [2:0] {
    ACT_CAP_OVERFLOW = 3'd0,
    ACT_CAP_EDGE     = 3'd1,
    ACT_GATE         = 3'd2,
    ACT_CNT_OVERFLOW = 3'd3,
    ACT_ACK          = 3'd4
  } action_e;

  localparam logic CFG_MEASURE_HIGH_LEVEL  = 1'b0;
  localparam logic CFG_FREQUENCY_THRESHOLD = 1'b1;

  localparam logic [31:0] THRESHOLD_RESET = 32'd500;
  localparam logic [31:0] EXT_COUNT_STEP  = 32'h0001_0000;
  localparam logic [5:0]  OVF_COUNT_MAX   = 6'h3F;
  localparam logic [15:0] WIDTH_SATURATED = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] count_value;
  } event_t;

  typedef struct packed {
    logic        measure_high_level;
    logic [31:0] frequency_threshold;
  } cfg_t;

  typedef struct packed {
    logic        capture_done;
    logic [5:0]  overflow_count;
    logic [15:0] width_value;
    logic [31:0] frequency;
    logic        capture_enabled;
    logic        wait_falling_edge;
    logic        restart_timer;
  } result_t;

endpackage

[src/fpc_engine.sv]
module fpc_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fpc_pkg::event_t  event_i,
  input  fpc_pkg::cfg_t    cfg_i,
  output fpc_pkg::result_t result_o
);

  logic        done_q, done_d;
  logic        started_q, started_d;
  logic [5:0]  ovf_count_q, ovf_count_d;
  logic [15:0] width_q, width_d;
  logic        falling_q, falling_d;
  logic        enabled_q, enabled_d;
  logic [31:0] ext_count_q, ext_count_d;
  logic [31:0] frequency_q, frequency_d;
  logic        restart;
  logic [31:0] freq_sum;

  assign freq_sum = ext_count_q + {16'd0, event_i.count_value};

  always_comb begin
    done_d      = done_q;
    started_d   = started_q;
    ovf_count_d = ovf_count_q;
    width_d     = width_q;
    falling_d   = falling_q;
    enabled_d   = enabled_q;
    ext_count_d = ext_count_q;
    frequency_d = frequency_q;
    restart     = 1'b0;
    unique case (event_i.action)
      fpc_pkg::ACT_CAP_OVERFLOW: begin
        if (enabled_q && !done_q && started_q) begin
          if (ovf_count_q == fpc_pkg::OVF_COUNT_MAX) begin
            done_d  = 1'b1;
            width_d = fpc_pkg::WIDTH_SATURATED;
          end else begin
            ovf_count_d = ovf_count_q + 6'd1;
          end
        end
      end
      fpc_pkg::ACT_CAP_EDGE: begin
        if (enabled_q && !done_q) begin
          if (started_q) begin
            done_d    = 1'b1;
            width_d   = event_i.count_value;
            falling_d = 1'b0;
          end else begin
            done_d      = 1'b0;
            started_d   = 1'b1;
            ovf_count_d = 6'd0;
            width_d     = 16'd0;
            restart     = 1'b1;
            falling_d   = cfg_i.measure_high_level;
          end
        end
      end
      fpc_pkg::ACT_GATE: begin
        frequency_d = freq_sum;
        ext_count_d = 32'd0;
        falling_d   = 1'b0;
        if (freq_sum >= cfg_i.frequency_threshold) begin
          enabled_d   = 1'b0;
          done_d      = 1'b0;
          started_d   = 1'b0;
          ovf_count_d = 6'd0;
          width_d     = 16'd0;
          restart     = 1'b1;
        end else begin
          enabled_d = 1'b1;
        end
      end
      fpc_pkg::ACT_CNT_OVERFLOW: begin
        ext_count_d = ext_count_q + fpc_pkg::EXT_COUNT_STEP;
      end
      fpc_pkg::ACT_ACK: begin
        done_d      = 1'b0;
        started_d   = 1'b0;
        ovf_count_d = 6'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.capture_done      = done_d;
    result_o.overflow_count    = ovf_count_d;
    result_o.width_value       = width_d;
    result_o.frequency         = frequency_d;
    result_o.capture_enabled   = enabled_d;
    result_o.wait_falling_edge = falling_d;
    result_o.restart_timer     = restart;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      started_q   <= 1'b0;
      ovf_count_q <= 6'd0;
      width_q     <= 16'd0;
      falling_q   <= 1'b0;
      enabled_q   <= 1'b1;
      ext_count_q <= 32'd0;
      frequency_q <= 32'd0;
    end else if (step_i) begin
      done_q      <= done_d;
      started_q   <= started_d;
      ovf_count_q <= ovf_count_d;
      width_q     <= width_d;
      falling_q   <= falling_d;
      enabled_q   <= enabled_d;
      ext_count_q <= ext_count_d;
      frequency_q <= frequency_d;
    end
  end

endmodule

[src/frequency_and_pulse_capture_core.sv]
// An accepted transaction is held in the event register, its result in the result
// register. Throughput: one transaction per cycle while out_ready_i does not stall
// the output; the event register and the state update in one pass set the pace.
// Reset: asynchronous, active low; clears both pipeline stages, sets capture enabled,
// all counts and flags to zero, measure_high_level to 0 and the threshold to 500.
module frequency_and_pulse_capture_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] count_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        capture_done_o,
  output logic [5:0]  overflow_count_o,
  output logic [15:0] width_value_o,
  output logic [31:0] frequency_o,
  output logic        capture_enabled_o,
  output logic        wait_falling_edge_o,
  output logic        restart_timer_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  fpc_pkg::cfg_t    cfg_q;
  fpc_pkg::event_t  event_q;
  fpc_pkg::result_t result;
  fpc_pkg::result_t result_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             step;

  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.measure_high_level  <= 1'b0;
      cfg_q.frequency_threshold <= fpc_pkg::THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fpc_pkg::CFG_MEASURE_HIGH_LEVEL:  cfg_q.measure_high_level  <= cfg_data_i[0];
        fpc_pkg::CFG_FREQUENCY_THRESHOLD: cfg_q.frequency_threshold <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      event_q.action      <= action_i;
      event_q.count_value <= count_value_i;
    end
    if (step) begin
      result_q <= result;
    end
  end

  fpc_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .event_i  (event_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_valid_o         = out_valid_q;
  assign capture_done_o      = result_q.capture_done;
  assign overflow_count_o    = result_q.overflow_count;
  assign width_value_o       = result_q.width_value;
  assign frequency_o         = result_q.frequency;
  assign capture_enabled_o   = result_q.capture_enabled;
  assign wait_falling_edge_o = result_q.wait_falling_edge;
  assign restart_timer_o     = result_q.restart_timer;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restart_timer_o |-> !capture_done_o && overflow_count_o == 6'd0)
    else $error("restart with capture status not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !capture_enabled_o |-> !capture_done_o)
    else $error("capture done while capture disabled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled with empty event register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(result_q))
    else $error("held result changed under backpressure");

endmodule

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_RESERVED_LO = 3'd5;

  class capture_scoreboard;
    logic             mode_high;
    logic [31:0]      threshold;
    logic             done;
    logic             started;
    logic [5:0]       ovf;
    logic [15:0]      width;
    logic             falling;
    logic             enabled;
    logic [31:0]      ext_count;
    logic [31:0]      freq;
    fpc_pkg::result_t status_q[$];
    int unsigned      mismatches;

    function new();
      mode_high  = 1'b0;
      threshold  = fpc_pkg::THRESHOLD_RESET;
      done       = 1'b0;
      started    = 1'b0;
      ovf        = '0;
      width      = '0;
      falling    = 1'b0;
      enabled    = 1'b1;
      ext_count  = '0;
      freq       = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
      if (idx == fpc_pkg::CFG_MEASURE_HIGH_LEVEL) begin
        mode_high = data[0];
      end else begin
        threshold = data;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_event(logic [2:0] act, logic [15:0] cv);
      fpc_pkg::result_t r;
      logic             kick;
      kick = 1'b0;
      case (act)
        fpc_pkg::ACT_CAP_OVERFLOW: begin
          if (enabled && !done && started) begin
            if (ovf == fpc_pkg::OVF_COUNT_MAX) begin
              done  = 1'b1;
              width = fpc_pkg::WIDTH_SATURATED;
            end else begin
              ovf = ovf + 6'd1;
            end
          end
        end
        fpc_pkg::ACT_CAP_EDGE: begin
          if (enabled && !done) begin
            if (started) begin
              done    = 1'b1;
              width   = cv;
              falling = 1'b0;
            end else begin
              ovf     = '0;
              width   = '0;
              started = 1'b1;
              kick    = 1'b1;
              falling = mode_high;
            end
          end
        end
        fpc_pkg::ACT_GATE: begin
          freq      = ext_count + {16'h0000, cv};
          ext_count = '0;
          falling   = 1'b0;
          if (freq >= threshold) begin
            enabled = 1'b0;
            done    = 1'b0;
            started = 1'b0;
            ovf     = '0;
            width   = '0;
            kick    = 1'b1;
          end else begin
            enabled = 1'b1;
          end
        end
        fpc_pkg::ACT_CNT_OVERFLOW: begin
          ext_count = ext_count + fpc_pkg::EXT_COUNT_STEP;
        end
        fpc_pkg::ACT_ACK: begin
          done    = 1'b0;
          started = 1'b0;
          ovf     = '0;
        end
        default: begin
        end
      endcase
      r.capture_done      = done;
      r.overflow_count    = ovf;
      r.width_value       = width;
      r.frequency         = freq;
      r.capture_enabled   = enabled;
      r.wait_falling_edge = falling;
      r.restart_timer     = kick;
      status_q.push_back(r);
    endfunction

    function void check_result(fpc_pkg::result_t got);
      fpc_pkg::result_t want;
      bit               bad;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction on output: %p", got);
        return;
      end
      want = status_q.pop_front();
      bad = (got.capture_done !== want.capture_done)
         || (got.overflow_count !== want.overflow_count)
         || (got.width_value !== want.width_value)
         || (got.frequency !== want.frequency)
         || (got.capture_enabled !== want.capture_enabled)
         || (got.wait_falling_edge !== want.wait_falling_edge)
         || (got.restart_timer !== want.restart_timer);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_action = '0;
  logic [15:0] in_count = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  logic        in_ready;
  logic        out_valid;
  logic        capture_done;
  logic [5:0]  overflow_count;
  logic [15:0] width_value;
  logic [31:0] frequency;
  logic        capture_enabled;
  logic        wait_falling_edge;
  logic        restart_timer;
  logic        cfg_ready;

  capture_scoreboard sb = new();
  fpc_pkg::result_t  observed;
  int                burst_left = 0;
  int                sent = 0;
  bit                hold_request = 1'b0;

  frequency_and_pulse_capture_core dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .action_i           (in_action),
    .count_value_i      (in_count),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .capture_done_o     (capture_done),
    .overflow_count_o   (overflow_count),
    .width_value_o      (width_value),
    .frequency_o        (frequency),
    .capture_enabled_o  (capture_enabled),
    .wait_falling_edge_o(wait_falling_edge),
    .restart_timer_o    (restart_timer),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed.capture_done      = capture_done;
      observed.overflow_count    = overflow_count;
      observed.width_value       = width_value;
      observed.frequency         = frequency;
      observed.capture_enabled   = capture_enabled;
      observed.wait_falling_edge = wait_falling_edge;
      observed.restart_timer     = restart_timer;
      sb.check_result(observed);
    end
  end

  initial begin
    logic [15:0] pattern;
    int          age;
    age = 0;
    pattern = '1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if (age == 0) begin
          pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
          age = $urandom_range(32, 128);
        end
        age--;
        out_ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  initial begin
    #20_000_000;
    $display("frequency_and_pulse_capture_core verification failed");
    $finish;
  end

  task automatic send_event(input logic [2:0] act, input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_count  <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_event(act, value);
    sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic run_measurement(input int n_ovf);
    logic [31:0] room;
    logic [15:0] cv;
    if (sb.ext_count < sb.threshold) begin
      room = sb.threshold - sb.ext_count - 32'd1;
      if (room > 32'h0000_FFFF) room = 32'h0000_FFFF;
      cv = 16'($urandom_range(0, room));
    end else begin
      cv = 16'($urandom);
    end
    send_event(fpc_pkg::ACT_GATE, cv);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'($urandom));
    for (int i = 0; i < n_ovf; i++) begin
      if ($urandom_range(0, 9) == 0) send_event(fpc_pkg::ACT_CNT_OVERFLOW, 16'($urandom));
      send_event(fpc_pkg::ACT_CAP_OVERFLOW, 16'($urandom));
    end
    if ($urandom_range(0, 4) != 0) send_event(fpc_pkg::ACT_CAP_EDGE, 16'($urandom));
    send_event(fpc_pkg::ACT_ACK, 16'($urandom));
  endtask

  task automatic run_random(input int target);
    int first;
    first = sent;
    while (sent - first < target) begin
      if ($urandom_range(0, 3) != 0) begin
        run_measurement(($urandom_range(0, 5) == 0) ? $urandom_range(62, 70)
                                                     : $urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(1, 4)) send_event(3'($urandom_range(0, 7)), 16'($urandom));
      end
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(fpc_pkg::ACT_CAP_OVERFLOW, 16'h1234);
    send_event(ACT_RESERVED_LO, 16'hFFFF);
    send_event(ACT_RESERVED_LO + 3'd1, 16'hAAAA);
    send_event(ACT_RESERVED_LO + 3'd2, 16'h5555);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h0000);
    send_event(fpc_pkg::ACT_CAP_OVERFLOW, 16'h0000);
    send_event(fpc_pkg::ACT_CAP_OVERFLOW, 16'hFFFF);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'hFFFF);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h0001);
    send_event(fpc_pkg::ACT_CAP_OVERFLOW, 16'h0000);
    send_event(fpc_pkg::ACT_ACK, 16'h0000);
    send_event(fpc_pkg::ACT_GATE, 16'h0000);
    send_event(fpc_pkg::ACT_CNT_OVERFLOW, 16'h0000);
    send_event(fpc_pkg::ACT_GATE, 16'hFFFF);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h0007);
    send_event(fpc_pkg::ACT_CAP_OVERFLOW, 16'h0000);
    send_event(fpc_pkg::ACT_GATE, 16'd499);
    send_event(fpc_pkg::ACT_GATE, 16'd500);
    send_event(fpc_pkg::ACT_GATE, 16'd12);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h0000);
    send_event(fpc_pkg::ACT_GATE, 16'd3);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h00F0);
    send_event(fpc_pkg::ACT_ACK, 16'h0000);

    write_reg(fpc_pkg::CFG_MEASURE_HIGH_LEVEL, 32'd1);
    run_measurement(0);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h0100);
    send_event(fpc_pkg::ACT_GATE, 16'hFFFF);
    send_event(fpc_pkg::ACT_GATE, 16'h0001);
    send_event(fpc_pkg::ACT_CAP_EDGE, 16'h0200);
    send_event(fpc_pkg::ACT_ACK, 16'h0000);
    run_measurement(64);

    write_reg(fpc_pkg::CFG_MEASURE_HIGH_LEVEL, 32'd0);
    write_reg(fpc_pkg::CFG_FREQUENCY_THRESHOLD, fpc_pkg::THRESHOLD_RESET);
    hold_request = 1'b1;
    run_random(110);

    write_reg(fpc_pkg::CFG_MEASURE_HIGH_LEVEL, 32'd1);
    write_reg(fpc_pkg::CFG_FREQUENCY_THRESHOLD, $urandom_range(1000, 100000));
    run_random(110);

    write_reg(fpc_pkg::CFG_FREQUENCY_THRESHOLD, 32'd0);
    run_random(100);

    write_reg(fpc_pkg::CFG_MEASURE_HIGH_LEVEL, 32'd0);
    write_reg(fpc_pkg::CFG_FREQUENCY_THRESHOLD, 32'hFFFF_FFFF);
    run_random(120);

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("frequency_and_pulse_capture_core verification clean");
    end else begin
      $display("frequency_and_pulse_capture_core verification failed");
    end
    $finish;
  end

endmodule
